[hdl/hashed_name_table_unit_macros.svh]
// assertion helpers shared by the checker
`ifndef HASHED_NAME_TABLE_UNIT_MACROS_SVH
`define HASHED_NAME_TABLE_UNIT_MACROS_SVH

// same-cycle implication, checked while out of reset
`define HNT_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked while out of reset
`define HNT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/hnt_pkg.sv]
package hnt_pkg;

	localparam logic [1:0] MODE_FIND   = 2'd0;
	localparam logic [1:0] MODE_INSERT = 2'd1;
	localparam logic [1:0] MODE_REMOVE = 2'd2;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_NOT_FOUND = 3'd1;
	localparam logic [2:0] ST_DUPLICATE = 3'd2;
	localparam logic [2:0] ST_FULL      = 3'd3;
	localparam logic [2:0] ST_EMPTY     = 3'd4;

	localparam logic [63:0] HASH_SEED  = 64'd5381;
	localparam int          HASH_SHIFT = 5;

	typedef struct packed {
		logic [1:0] mode;
		logic [7:0] name_char;
		logic       last_char;
	} hnt_req_t;

	typedef struct packed {
		logic [2:0] status;
		logic [5:0] slot_index;
	} hnt_rsp_t;

endpackage

[hdl/hnt_stream_if.sv]
interface hnt_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[hdl/hashed_name_table_unit.sv]
// hashed name table: a name arrives on req one character per transaction,
// with mode (find, insert, remove) and last_char. zero characters are dropped.
// characters are taken back to back while idle. the last one starts the
// table operation and yields exactly one rsp transaction (status, slot_index).
// a last character starts bucket reduction (the 64-bit djb2 hash taken mod
// BUCKETS four bits a cycle), a read of the chain head, then a compare per
// character and a hop per chain node on the single-port name store. an
// insert that finds no match then scans the used flags slot by slot for a
// free one, copies the name and links it. a result leaves through an output
// register: req is taken again as soon as the result is loaded, even while
// rsp is stalled; the result of a further last character waits until the
// earlier result has been taken. after reset a clearing pass over
// max(BUCKETS, SLOTS) addresses empties the bucket heads and used flags;
// req.ready stays low until it is done.
module hashed_name_table_unit
	import hnt_pkg::*;
#(
	parameter int BUCKETS  = 64,
	parameter int NAME_LEN = 32,
	parameter int SLOTS    = 64
) (
	input logic              clk,
	input logic              arst_n,
	hnt_stream_if.sink       req,
	hnt_stream_if.source     rsp
);

	localparam int BW    = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int PW    = $clog2(SLOTS + 1);
	localparam int LW    = $clog2(NAME_LEN + 1);
	localparam int QW    = $clog2(NAME_LEN);
	localparam int AW    = (SLOTS * NAME_LEN > 1) ? $clog2(SLOTS * NAME_LEN) : 1;
	localparam int MW    = BW + 4;
	localparam int CLR_N = (BUCKETS > SLOTS) ? BUCKETS : SLOTS;
	localparam int CW    = $clog2(CLR_N + 1);

	localparam logic [PW-1:0] EMPTY_MARK = PW'(SLOTS);
	localparam logic [LW-1:0] LEN_MAX    = LW'(NAME_LEN);
	localparam logic [LW-1:0] KEEP_MAX   = LW'(NAME_LEN - 1);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_CLR   = 4'd1;
	localparam logic [3:0] S_MOD   = 4'd2;
	localparam logic [3:0] S_HEAD  = 4'd3;
	localparam logic [3:0] S_HEADW = 4'd4;
	localparam logic [3:0] S_NODE  = 4'd5;
	localparam logic [3:0] S_REQ   = 4'd6;
	localparam logic [3:0] S_CHK   = 4'd7;
	localparam logic [3:0] S_OP    = 4'd8;
	localparam logic [3:0] S_FREE  = 4'd9;
	localparam logic [3:0] S_FREEW = 4'd10;
	localparam logic [3:0] S_COPY  = 4'd11;
	localparam logic [3:0] S_LINK  = 4'd12;
	localparam logic [3:0] S_DONE  = 4'd13;

	// memories
	logic [7:0]    qc_mem [NAME_LEN];
	logic [7:0]    sc_mem [SLOTS * NAME_LEN];
	logic [PW-1:0] su_mem [SLOTS];
	logic [PW-1:0] hd_mem [BUCKETS];
	logic          us_mem [SLOTS];

	logic [3:0]    state_q;
	logic [CW-1:0] clr_q;
	logic [63:0]   hash_q;
	logic [LW-1:0] qlen_q;
	logic [1:0]    mode_q;
	logic [3:0]    nib_q;
	logic [BW-1:0] rem_q;
	logic [PW-1:0] head_q;
	logic [PW-1:0] cur_q;
	logic [PW-1:0] prev_q;
	logic [PW-1:0] found_q;
	logic [PW-1:0] fsucc_q;
	logic [AW-1:0] base_q;
	logic [LW-1:0] idx_q;
	logic [LW-1:0] keep_q;
	logic [SW-1:0] free_q;
	logic [LW-1:0] idx_s1;
	logic          wr_s1;
	logic [2:0]    status_q;
	logic [SW-1:0] slot_q;
	logic          ov_q;
	hnt_rsp_t      od_q;

	logic [7:0]    qc_rd;
	logic [7:0]    sc_rd;
	logic [PW-1:0] su_rd;
	logic [PW-1:0] hd_rd;
	logic          us_rd;

	logic          acc;
	logic [MW-1:0] red;
	logic [7:0]    expect_c;

	logic          hd_we;
	logic [BW-1:0] hd_wa;
	logic [PW-1:0] hd_wd;
	logic          su_we;
	logic [SW-1:0] su_wa;
	logic [PW-1:0] su_wd;
	logic          us_we;
	logic [SW-1:0] us_wa;
	logic          us_wd;
	logic [AW-1:0] sc_addr;

	assign req.ready = (state_q == S_IDLE);
	assign acc       = req.valid && req.ready;
	assign rsp.valid = ov_q;
	assign rsp.data  = od_q;

	// one nibble of the hash folded into the remainder per cycle
	always_comb begin
		red = {rem_q, hash_q[63:60]};
		for (int k = 3; k >= 0; k--) begin
			if (red >= (MW'(BUCKETS) << k))
				red = red - (MW'(BUCKETS) << k);
		end
	end

	assign expect_c = (idx_q == qlen_q) ? 8'h00 : qc_rd;
	assign sc_addr  = wr_s1 ? base_q + AW'(idx_s1) : base_q + AW'(idx_q);

	always_comb begin
		hd_we = 1'b0;
		hd_wa = rem_q;
		hd_wd = EMPTY_MARK;
		su_we = 1'b0;
		su_wa = prev_q[SW-1:0];
		su_wd = fsucc_q;
		us_we = 1'b0;
		us_wa = found_q[SW-1:0];
		us_wd = 1'b0;
		unique case (state_q)
			S_CLR: begin
				hd_we = clr_q < CW'(BUCKETS);
				hd_wa = clr_q[BW-1:0];
				us_we = clr_q < CW'(SLOTS);
				us_wa = clr_q[SW-1:0];
			end
			S_OP: begin
				if (mode_q == MODE_REMOVE && found_q != EMPTY_MARK) begin
					us_we = 1'b1;
					if (prev_q == EMPTY_MARK) begin
						hd_we = 1'b1;
						hd_wd = fsucc_q;
					end else begin
						su_we = 1'b1;
					end
				end
			end
			S_LINK: begin
				hd_we = 1'b1;
				hd_wd = PW'(free_q);
				su_we = 1'b1;
				su_wa = free_q;
				su_wd = head_q;
				us_we = 1'b1;
				us_wa = free_q;
				us_wd = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (acc && req.data.name_char != 8'h00 && qlen_q < LEN_MAX)
			qc_mem[qlen_q[QW-1:0]] <= req.data.name_char;
		qc_rd <= qc_mem[idx_q[QW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (wr_s1)
			sc_mem[sc_addr] <= (idx_s1 == keep_q) ? 8'h00 : qc_rd;
		sc_rd <= sc_mem[sc_addr];
	end

	always_ff @(posedge clk) begin
		if (su_we)
			su_mem[su_wa] <= su_wd;
		su_rd <= su_mem[cur_q[SW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (hd_we)
			hd_mem[hd_wa] <= hd_wd;
		hd_rd <= hd_mem[rem_q];
	end

	always_ff @(posedge clk) begin
		if (us_we)
			us_mem[us_wa] <= us_wd;
		us_rd <= us_mem[free_q];
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (acc)
					mode_q <= req.data.mode;
			end
			S_HEADW: begin
				head_q  <= hd_rd;
				cur_q   <= hd_rd;
				prev_q  <= EMPTY_MARK;
				found_q <= EMPTY_MARK;
			end
			S_NODE: begin
				base_q <= AW'(cur_q[SW-1:0]) * AW'(NAME_LEN);
				idx_q  <= '0;
			end
			S_REQ: begin
			end
			S_CHK: begin
				if (sc_rd != expect_c) begin
					prev_q <= cur_q;
					cur_q  <= su_rd;
				end else if (idx_q == qlen_q) begin
					found_q <= cur_q;
					fsucc_q <= su_rd;
				end else begin
					idx_q <= idx_q + 1'b1;
				end
			end
			S_FREEW: begin
				if (!us_rd) begin
					base_q <= AW'(free_q) * AW'(NAME_LEN);
					idx_q  <= '0;
					keep_q <= (qlen_q < KEEP_MAX) ? qlen_q : KEEP_MAX;
				end
			end
			S_COPY: begin
				idx_s1 <= idx_q;
				if (idx_q != keep_q)
					idx_q <= idx_q + 1'b1;
			end
			default: begin
			end
		endcase
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLR;
			clr_q    <= '0;
			hash_q   <= HASH_SEED;
			qlen_q   <= '0;
			nib_q    <= '0;
			rem_q    <= '0;
			free_q   <= '0;
			wr_s1    <= 1'b0;
			status_q <= ST_NOT_FOUND;
			slot_q   <= '0;
			ov_q     <= 1'b0;
			od_q     <= '0;
		end else begin
			wr_s1 <= (state_q == S_COPY);
			if (state_q == S_DONE && (!ov_q || rsp.ready))
				ov_q <= 1'b1;
			else if (ov_q && rsp.ready)
				ov_q <= 1'b0;
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == CW'(CLR_N - 1))
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (acc) begin
						if (req.data.name_char != 8'h00) begin
							hash_q <= (hash_q << HASH_SHIFT) + hash_q
								+ 64'(req.data.name_char);
							if (qlen_q < LEN_MAX)
								qlen_q <= qlen_q + 1'b1;
						end
						if (req.data.last_char) begin
							nib_q   <= '0;
							rem_q   <= '0;
							state_q <= S_MOD;
						end
					end
				end
				S_MOD: begin
					rem_q  <= red[BW-1:0];
					hash_q <= hash_q << 4;
					nib_q  <= nib_q + 1'b1;
					if (nib_q == 4'hf)
						state_q <= S_HEAD;
				end
				S_HEAD: state_q <= S_HEADW;
				S_HEADW: begin
					slot_q <= '0;
					if (mode_q == MODE_INSERT && qlen_q == '0) begin
						status_q <= ST_EMPTY;
						state_q  <= S_DONE;
					end else begin
						status_q <= ST_NOT_FOUND;
						state_q  <= (qlen_q >= LEN_MAX) ? S_OP : S_NODE;
					end
				end
				S_NODE: state_q <= (cur_q == EMPTY_MARK) ? S_OP : S_REQ;
				S_REQ: state_q <= S_CHK;
				S_CHK: begin
					if (sc_rd != expect_c)
						state_q <= S_NODE;
					else if (idx_q == qlen_q)
						state_q <= S_OP;
					else
						state_q <= S_REQ;
				end
				S_OP: begin
					case (mode_q)
						MODE_INSERT: begin
							if (found_q != EMPTY_MARK) begin
								status_q <= ST_DUPLICATE;
								state_q  <= S_DONE;
							end else begin
								free_q  <= '0;
								state_q <= S_FREE;
							end
						end
						default: begin
							state_q <= S_DONE;
							if (found_q != EMPTY_MARK) begin
								status_q <= ST_OK;
								slot_q   <= found_q[SW-1:0];
							end
						end
					endcase
				end
				S_FREE: state_q <= S_FREEW;
				S_FREEW: begin
					if (!us_rd) begin
						state_q <= S_COPY;
					end else if (free_q == SW'(SLOTS - 1)) begin
						status_q <= ST_FULL;
						state_q  <= S_DONE;
					end else begin
						free_q  <= free_q + 1'b1;
						state_q <= S_FREE;
					end
				end
				S_COPY: begin
					if (idx_q == keep_q)
						state_q <= S_LINK;
				end
				S_LINK: begin
					status_q <= ST_OK;
					slot_q   <= free_q;
					state_q  <= S_DONE;
				end
				S_DONE: begin
					if (!ov_q || rsp.ready) begin
						od_q.status     <= status_q;
						od_q.slot_index <= (status_q == ST_OK) ? 6'(slot_q) : 6'd0;
						hash_q          <= HASH_SEED;
						qlen_q          <= '0;
						state_q         <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

[hdl/hnt_checker.sv]
`include "hashed_name_table_unit_macros.svh"

module hnt_checker
	import hnt_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       req_valid,
	input logic       req_ready,
	input logic       req_last,
	input logic       rsp_valid,
	input logic       rsp_ready,
	input logic [2:0] rsp_status,
	input logic [5:0] rsp_slot
);

	logic [1:0] pend_q;
	logic       req_end;
	logic       rsp_acc;

	assign req_end = req_valid && req_ready && req_last;
	assign rsp_acc = rsp_valid && rsp_ready;

	// last-character transactions still owed a result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pend_q <= '0;
		else
			pend_q <= pend_q + {1'b0, req_end} - {1'b0, rsp_acc};
	end

	`HNT_ASSERT_NOW(a_rsp_owed, rsp_valid, pend_q != 2'd0, "result without a name")
	`HNT_ASSERT_NOW(a_pend_bound, 1'b1, pend_q <= 2'd2, "too many names in flight")
	`HNT_ASSERT_NOW(a_slot_zero, rsp_valid && rsp_status != ST_OK, rsp_slot == 6'd0,
		"slot set on failure")
	`HNT_ASSERT_NEXT(a_busy, req_end, !req_ready, "ready after last character")
	`HNT_ASSERT_NEXT(a_hold, rsp_valid && !rsp_ready, rsp_valid, "result dropped")

endmodule

bind hashed_name_table_unit hnt_checker u_hnt_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req.valid),
	.req_ready  (req.ready),
	.req_last   (req.data.last_char),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.rsp_status (rsp.data.status),
	.rsp_slot   (rsp.data.slot_index)
);
